[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the checker file hrmw_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

[rtl/core/hrmw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrmw_pkg
// Shared types, character codes and the hex digit decode for the hex record
// to memory write converter.
// ----------------------------------------------------------------------------
package hrmw_pkg;

   localparam logic [7:0] COLON_CHAR = 8'h3A;
   localparam logic [7:0] DIGIT_LO   = 8'h30;
   localparam logic [7:0] DIGIT_HI   = 8'h39;
   localparam logic [7:0] UPPER_LO   = 8'h41;
   localparam logic [7:0] UPPER_HI   = 8'h46;
   localparam logic [7:0] LOWER_LO   = 8'h61;
   localparam logic [7:0] LOWER_HI   = 8'h66;
   localparam logic [7:0] UPPER_BIAS = 8'h37;
   localparam logic [7:0] LOWER_BIAS = 8'h57;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_END   = 1'b1;

   localparam logic [9:0] POS_COUNT_END = 10'd2;
   localparam logic [9:0] POS_ADDR_END  = 10'd6;
   localparam logic [9:0] POS_TYPE_END  = 10'd8;

   typedef struct packed {
      logic       valid;
      logic [7:0] ascii_char;
   } stage_type;

   typedef struct packed {
      logic        result_kind;
      logic [15:0] write_address;
      logic [7:0]  write_byte;
   } result_type;

   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      logic [3:0] nib;
      nib = 4'd0;
      if (c inside {[DIGIT_LO:DIGIT_HI]}) begin
         nib = 4'(c - DIGIT_LO);
      end else if (c inside {[UPPER_LO:UPPER_HI]}) begin
         nib = 4'(c - UPPER_BIAS);
      end else if (c inside {[LOWER_LO:LOWER_HI]}) begin
         nib = 4'(c - LOWER_BIAS);
      end
      return nib;
   endfunction

endpackage

[rtl/core/hrmw_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrmw_if
// Valid/ready channels: character requests in, memory write responses out.
// ----------------------------------------------------------------------------
interface hrmw_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ascii_char;

   modport source (output valid, output ascii_char, input ready);
   modport sink   (input valid, input ascii_char, output ready);
endinterface

interface hrmw_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [15:0] write_address;
   logic [7:0]  write_byte;

   modport source (output valid, output result_kind, output write_address,
                   output write_byte, input ready);
   modport sink   (input valid, input result_kind, input write_address,
                   input write_byte, output ready);
endinterface

[rtl/core/hrmw_in_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrmw_in_stage
// Input register: captures one character per transfer, holds while stalled.
// ----------------------------------------------------------------------------
module hrmw_in_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [7:0]          req_ascii_char,
   output logic                req_ready,
   input  logic                advance,
   output hrmw_pkg::stage_type stage
);

   logic       valid_ff, valid_in;
   logic [7:0] char_ff;

   assign req_ready = !valid_ff || advance;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         char_ff <= req_ascii_char;
      end
   end

   assign stage.valid      = valid_ff;
   assign stage.ascii_char = char_ff;

endmodule

[rtl/core/hrmw_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrmw_parser
// Record field state and per-character decode; yields at most one result
// for each consumed character.
// ----------------------------------------------------------------------------
module hrmw_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  hrmw_pkg::stage_type  stage,
   input  logic                 advance,
   input  logic                 csr_wr_en,
   input  logic [15:0]          csr_wr_data,
   output logic                 result_valid,
   output hrmw_pkg::result_type result
);

   logic [15:0] offset_ff;
   logic        in_record_ff, in_record_in;
   logic [9:0]  char_position_ff, char_position_in;
   logic [7:0]  byte_count_ff, byte_count_in;
   logic [15:0] record_address_ff, record_address_in;
   logic [7:0]  record_type_ff, record_type_in;
   logic [3:0]  high_nibble_ff, high_nibble_in;
   logic [7:0]  bytes_done_ff, bytes_done_in;

   logic        consume;
   logic [3:0]  nib;
   logic [9:0]  pos;
   logic [7:0]  done_next;

   assign consume   = stage.valid && advance;
   assign nib       = hrmw_pkg::nibble_of(stage.ascii_char);
   assign pos       = char_position_ff + 10'd1;
   assign done_next = bytes_done_ff + 8'd1;

   always_comb begin
      in_record_in      = in_record_ff;
      char_position_in  = char_position_ff;
      byte_count_in     = byte_count_ff;
      record_address_in = record_address_ff;
      record_type_in    = record_type_ff;
      high_nibble_in    = high_nibble_ff;
      bytes_done_in     = bytes_done_ff;
      result_valid      = 1'b0;
      result            = '0;
      if (stage.ascii_char == hrmw_pkg::COLON_CHAR) begin
         in_record_in      = 1'b1;
         char_position_in  = '0;
         byte_count_in     = '0;
         record_address_in = '0;
         record_type_in    = '0;
         high_nibble_in    = '0;
         bytes_done_in     = '0;
      end else if (in_record_ff) begin
         char_position_in = pos;
         if (pos <= hrmw_pkg::POS_COUNT_END) begin
            byte_count_in = {byte_count_ff[3:0], nib};
         end else if (pos <= hrmw_pkg::POS_ADDR_END) begin
            record_address_in = {record_address_ff[11:0], nib};
         end else if (pos <= hrmw_pkg::POS_TYPE_END) begin
            record_type_in = {record_type_ff[3:0], nib};
            if (pos == hrmw_pkg::POS_TYPE_END &&
                (byte_count_ff == 8'd0 || record_type_in != 8'd0)) begin
               in_record_in       = 1'b0;
               result_valid       = 1'b1;
               result.result_kind = hrmw_pkg::KIND_END;
            end
         end else if (pos[0]) begin
            high_nibble_in = nib;
         end else begin
            bytes_done_in = done_next;
            if (done_next == byte_count_ff) begin
               in_record_in = 1'b0;
            end
            result_valid         = 1'b1;
            result.result_kind   = hrmw_pkg::KIND_WRITE;
            result.write_address = record_address_ff + {8'd0, bytes_done_ff} + offset_ff;
            result.write_byte    = {high_nibble_ff, nib};
         end
      end
      if (!consume) begin
         result_valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff         <= '0;
         in_record_ff      <= 1'b0;
         char_position_ff  <= '0;
         byte_count_ff     <= '0;
         record_address_ff <= '0;
         record_type_ff    <= '0;
         high_nibble_ff    <= '0;
         bytes_done_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            offset_ff <= csr_wr_data;
         end
         if (consume) begin
            in_record_ff      <= in_record_in;
            char_position_ff  <= char_position_in;
            byte_count_ff     <= byte_count_in;
            record_address_ff <= record_address_in;
            record_type_ff    <= record_type_in;
            high_nibble_ff    <= high_nibble_in;
            bytes_done_ff     <= bytes_done_in;
         end
      end
   end

endmodule

[rtl/core/hrmw_out_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrmw_out_stage
// Result register: loads a result when free or drained, holds while the
// response side stalls.
// ----------------------------------------------------------------------------
module hrmw_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 result_valid,
   input  hrmw_pkg::result_type result,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output hrmw_pkg::result_type rsp_data,
   output logic                 advance
);

   logic                 valid_ff, valid_in;
   hrmw_pkg::result_type data_ff;

   assign advance  = !valid_ff || rsp_ready;
   assign valid_in = advance ? result_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result_valid) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

[rtl/core/hex_record_to_memory_writes_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_record_to_memory_writes_top
// Hex record character stream to byte memory writes and end markers.
// ----------------------------------------------------------------------------
// Requests pass the input register, parser and result register to rsp_if.
// Throughput: one character per cycle, set by the input and result registers,
// while rsp_if does not stall. A stalled response holds the result register;
// the input side keeps transferring until the input register is also full.
// Reset (synchronous): clears valid flags, record state and base offset.
module hex_record_to_memory_writes_top (
   input  logic        clock,
   input  logic        reset,
   hrmw_req_if.sink    req_if,
   hrmw_rsp_if.source  rsp_if,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   hrmw_pkg::stage_type  stage;
   hrmw_pkg::result_type result;
   hrmw_pkg::result_type rsp_data;
   logic                 result_valid;
   logic                 advance;
   logic                 ready;
   logic                 rsp_valid;

   hrmw_in_stage u_in_stage (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_if.valid),
      .req_ascii_char (req_if.ascii_char),
      .req_ready      (ready),
      .advance        (advance),
      .stage          (stage)
   );

   hrmw_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .stage        (stage),
      .advance      (advance),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .result_valid (result_valid),
      .result       (result)
   );

   hrmw_out_stage u_out_stage (
      .clock        (clock),
      .reset        (reset),
      .result_valid (result_valid),
      .result       (result),
      .rsp_ready    (rsp_if.ready),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data),
      .advance      (advance)
   );

   assign req_if.ready         = ready;
   assign rsp_if.valid         = rsp_valid;
   assign rsp_if.result_kind   = rsp_data.result_kind;
   assign rsp_if.write_address = rsp_data.write_address;
   assign rsp_if.write_byte    = rsp_data.write_byte;

endmodule

[rtl/core/hrmw_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrmw_checker
// Port-level checks on the converter, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hrmw_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_result_kind,
   input logic [15:0] rsp_write_address,
   input logic [7:0]  rsp_write_byte
);

   logic end_seen;
   logic end_clear;

   assign end_seen  = rsp_valid && (rsp_result_kind == hrmw_pkg::KIND_END);
   assign end_clear = (rsp_write_address == 16'd0) && (rsp_write_byte == 8'd0);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ASSERT_IMPLY(a_end_zero, clock, reset, end_seen, end_clear)
   `ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid)
   `ASSERT_IMPLY(a_rsp_cause, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready, 2))

endmodule

bind hex_record_to_memory_writes_top hrmw_checker u_hrmw_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_if.valid),
   .req_ready         (req_if.ready),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_result_kind   (rsp_if.result_kind),
   .rsp_write_address (rsp_if.write_address),
   .rsp_write_byte    (rsp_if.write_byte)
);

[sim/tb_hex_record_to_memory_writes_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hex_record_to_memory_writes_top
// Drives character streams of hex records into the converter and checks every
// byte write and end marker against a cycle-free predictor of the parser.
// Data, end, truncated and noisy records are mixed over several base offsets,
// with random gaps on both channels and two long response hold-offs that back
// up the request side.
// ----------------------------------------------------------------------------
module tb_hex_record_to_memory_writes_top;

   localparam logic [7:0] CR_CHAR = 8'h0D;
   localparam logic [7:0] LF_CHAR = 8'h0A;
   localparam int DRAIN_CYCLES    = 6;
   localparam int PHASE_CHARS     = 400;
   localparam int HOLD_CYCLES     = 80;

   typedef enum int {REC_DATA, REC_END, REC_BROKEN, REC_NOISE} record_kind_type;

   class write_forecast;
      logic [15:0]          base_offset;
      bit                   in_record;
      logic [9:0]           char_pos;
      logic [7:0]           byte_count;
      logic [15:0]          rec_addr;
      logic [7:0]           rec_type;
      logic [3:0]           high_nib;
      logic [7:0]           bytes_done;
      hrmw_pkg::result_type pending_writes[$];

      function new();
         base_offset = '0;
         clear_record();
         in_record = 1'b0;
      endfunction

      function void clear_record();
         char_pos   = '0;
         byte_count = '0;
         rec_addr   = '0;
         rec_type   = '0;
         high_nib   = '0;
         bytes_done = '0;
      endfunction

      function logic [3:0] digit_value(input logic [7:0] c);
         if (c >= hrmw_pkg::DIGIT_LO && c <= hrmw_pkg::DIGIT_HI) return c[3:0];
         if ((c >= hrmw_pkg::UPPER_LO && c <= hrmw_pkg::UPPER_HI) ||
             (c >= hrmw_pkg::LOWER_LO && c <= hrmw_pkg::LOWER_HI))
            return 4'(c[3:0] + 4'd9);
         return 4'd0;
      endfunction

      function int pending();
         return pending_writes.size();
      endfunction

      function void take_char(input logic [7:0] c);
         logic [3:0]           nib;
         int                   p;
         hrmw_pkg::result_type w;
         if (c == hrmw_pkg::COLON_CHAR) begin
            clear_record();
            in_record = 1'b1;
            return;
         end
         if (!in_record) return;
         nib      = digit_value(c);
         p        = int'(char_pos) + 1;
         char_pos = p[9:0];
         if (p <= 2) begin
            byte_count = {byte_count[3:0], nib};
         end else if (p <= 6) begin
            rec_addr = {rec_addr[11:0], nib};
         end else if (p <= 8) begin
            rec_type = {rec_type[3:0], nib};
            if (p == 8 && (byte_count == 8'd0 || rec_type != 8'd0)) begin
               in_record       = 1'b0;
               w.result_kind   = hrmw_pkg::KIND_END;
               w.write_address = '0;
               w.write_byte    = '0;
               pending_writes.push_back(w);
            end
         end else if (((p - 9) & 1) == 0) begin
            high_nib = nib;
         end else begin
            w.result_kind   = hrmw_pkg::KIND_WRITE;
            w.write_address = 16'(rec_addr + 16'(bytes_done) + base_offset);
            w.write_byte    = {high_nib, nib};
            pending_writes.push_back(w);
            bytes_done = bytes_done + 8'd1;
            if (bytes_done == byte_count) in_record = 1'b0;
         end
      endfunction

      function int match_write(input hrmw_pkg::result_type got, output string why);
         hrmw_pkg::result_type want;
         int                   bad;
         bad = 0;
         why = "";
         if (pending_writes.size() == 0) begin
            why = $sformatf("unexpected response kind %0d addr %h byte %h",
                            got.result_kind, got.write_address, got.write_byte);
            return 1;
         end
         want = pending_writes.pop_front();
         if (got.result_kind !== want.result_kind) begin
            bad++;
            why = {why, $sformatf(" kind got %0d want %0d", got.result_kind,
                                  want.result_kind)};
         end
         if (got.write_address !== want.write_address) begin
            bad++;
            why = {why, $sformatf(" addr got %h want %h", got.write_address,
                                  want.write_address)};
         end
         if (got.write_byte !== want.write_byte) begin
            bad++;
            why = {why, $sformatf(" byte got %h want %h", got.write_byte,
                                  want.write_byte)};
         end
         return bad;
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   hrmw_req_if req_bus ();
   hrmw_rsp_if rsp_bus ();

   hex_record_to_memory_writes_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   write_forecast        writes = new();
   int                   mismatch_count = 0;
   int                   chars_sent = 0;
   int                   results_seen = 0;
   bit                   burst_mode = 1'b0;
   hrmw_pkg::result_type got_write;
   string                why;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #5ms;
      $display("== FAIL ==");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t:%s", $time, msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got_write.result_kind   = rsp_bus.result_kind;
            got_write.write_address = rsp_bus.write_address;
            got_write.write_byte    = rsp_bus.write_byte;
            results_seen++;
            if (writes.match_write(got_write, why) != 0) report_mismatch(why);
         end
         if (req_bus.valid && req_bus.ready) writes.take_char(req_bus.ascii_char);
      end
   end

   // response side: random stalls, two long hold-offs
   initial begin
      int gap;
      bit held_first;
      bit held_second;
      held_first  = 1'b0;
      held_second = 1'b0;
      rsp_bus.ready = 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         gap = burst_mode ? 0 : $urandom_range(0, 4);
         if (!held_first && results_seen >= 150) begin
            gap        = HOLD_CYCLES;
            held_first = 1'b1;
         end else if (!held_second && results_seen >= 700) begin
            gap         = HOLD_CYCLES;
            held_second = 1'b1;
         end
         repeat (gap) begin
            rsp_bus.ready <= 1'b0;
            @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
      end
   end

   task automatic send_char(input logic [7:0] c);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 4);
      repeat (gap) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.ascii_char <= c;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      chars_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   task automatic send_hex(input logic [15:0] value, input int digits);
      logic [3:0] d;
      for (int i = digits - 1; i >= 0; i--) begin
         d = value[i*4 +: 4];
         if (d < 4'd10) send_char(hrmw_pkg::DIGIT_LO + 8'(d));
         else send_char(($urandom_range(0, 1) ? hrmw_pkg::LOWER_LO : hrmw_pkg::UPPER_LO)
                        + 8'(d) - 8'd10);
      end
   endtask

   task automatic send_line_end();
      if ($urandom_range(0, 1)) send_char(CR_CHAR);
      send_char(LF_CHAR);
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (writes.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_offset(input logic [15:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      writes.base_offset = value;
   endtask

   task automatic send_record(input record_kind_type kind);
      int          count;
      int          cut;
      logic [15:0] addr;
      logic [7:0]  rtype;
      logic [7:0]  data;
      logic [7:0]  sum;
      addr = 16'($urandom_range(0, 65535));
      case (kind)
         REC_DATA: begin
            if ($urandom_range(0, 59) == 0) count = $urandom_range(9, 255);
            else count = $urandom_range(1, 8);
            sum = 8'(count) + addr[15:8] + addr[7:0];
            send_char(hrmw_pkg::COLON_CHAR);
            send_hex(16'(count), 2);
            send_hex(addr, 4);
            send_hex(16'd0, 2);
            for (int i = 0; i < count; i++) begin
               data = 8'($urandom_range(0, 255));
               sum  = sum + data;
               send_hex({8'd0, data}, 2);
            end
            send_hex({8'd0, 8'(-sum)}, 2);
            send_line_end();
         end
         REC_END: begin
            if ($urandom_range(0, 1)) begin
               count = 0;
               rtype = 8'($urandom_range(0, 255));
            end else begin
               count = $urandom_range(1, 255);
               rtype = 8'($urandom_range(1, 255));
            end
            send_char(hrmw_pkg::COLON_CHAR);
            send_hex(16'(count), 2);
            send_hex(addr, 4);
            send_hex({8'd0, rtype}, 2);
            send_hex(16'($urandom_range(0, 255)), 2);
            send_line_end();
         end
         REC_BROKEN: begin
            count = $urandom_range(1, 8);
            cut   = $urandom_range(0, 2 * count + 8);
            send_char(hrmw_pkg::COLON_CHAR);
            for (int i = 0; i < cut; i++) begin
               if ($urandom_range(0, 3) == 0) send_char(8'($urandom_range(0, 255)));
               else if (i < 2) send_hex(16'(count >> (4 * (1 - i))), 1);
               else if (i >= 6 && i < 8) send_char(hrmw_pkg::DIGIT_LO);
               else send_hex(16'($urandom_range(0, 15)), 1);
            end
         end
         default: begin
            cut = $urandom_range(1, 6);
            for (int i = 0; i < cut; i++) send_char(8'($urandom_range(0, 255)));
         end
      endcase
   endtask

   initial begin
      int          pick;
      int          phase_end;
      logic [15:0] offsets[4];
      req_bus.valid      = 1'b0;
      req_bus.ascii_char = '0;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      wait (!reset);
      @(posedge clock);
      write_offset(16'h0000);

      send_char(8'h00);
      send_char(8'hFF);
      send_text(":00000001");
      send_text(":0:01FFFF00fA");
      send_text(":01000000\r\n");
      send_text(":01123404");
      send_text(":02ABCD00Bc5e");
      wait_idle();
      write_offset(16'hFFFF);
      send_text(":02FFFF00ee11");
      wait_idle();

      offsets[0] = 16'hFFFF;
      offsets[1] = 16'($urandom_range(0, 65535));
      offsets[2] = 16'($urandom_range(0, 65535));
      offsets[3] = 16'h0000;
      for (int ph = 0; ph < 4; ph++) begin
         write_offset(offsets[ph]);
         burst_mode = (ph == 1);
         phase_end  = chars_sent + PHASE_CHARS;
         while (chars_sent < phase_end) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) send_record(REC_DATA);
            else if (pick < 80) send_record(REC_END);
            else if (pick < 90) send_record(REC_BROKEN);
            else send_record(REC_NOISE);
         end
         wait_idle();
      end

      if (writes.pending() != 0) report_mismatch(" responses missing at end of run");
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[hex_record_to_memory_writes_top.f]
+incdir+rtl/core
rtl/core/hrmw_pkg.sv
rtl/core/hrmw_if.sv
rtl/core/hrmw_in_stage.sv
rtl/core/hrmw_parser.sv
rtl/core/hrmw_out_stage.sv
rtl/core/hex_record_to_memory_writes_top.sv
rtl/core/hrmw_checker.sv
sim/tb_hex_record_to_memory_writes_top.sv
